[sv/rmq_pkg.sv]
// Shared constants, widths and types for the rotation matrix to quaternion pipeline.
package rmq_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int WORD_WIDTH = 16;

    localparam int W  = WORD_WIDTH;
    localparam int AW = W + 2;                   // signed root argument width
    localparam int NW = AW - 1 + FRAC_BITS;      // radicand width
    localparam int RW = (NW + 1) / 2;            // root width
    localparam int MW = W + 1;                   // numerator magnitude width
    localparam int DW = MW + FRAC_BITS + 1;      // scaled dividend width
    localparam int XW = (DW > RW + 1 + W) ? DW : RW + 1 + W;

    localparam logic [W-1:0] WMAX_U = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN_U = {1'b1, {(W-1){1'b0}}};
    localparam logic [AW-1:0] ONE   = AW'(1) << FRAC_BITS;

    localparam logic [1:0] PC_TRACE = 2'd0;
    localparam logic [1:0] PC_M00   = 2'd1;
    localparam logic [1:0] PC_M11   = 2'd2;
    localparam logic [1:0] PC_M22   = 2'd3;

    typedef logic [W-1:0]  t_word;
    typedef logic [MW-1:0] t_mag;
    typedef logic [RW-1:0] t_root;

    typedef struct packed {
        logic [1:0] pc;
        logic       degen;
        logic [2:0] neg;
        t_mag [2:0] mag;
    } t_front;

    typedef struct packed {
        logic [1:0] pc;
        logic       degen;
        logic [2:0] neg;
        t_word      pivot;
    } t_side;

endpackage

[sv/rmq_front.sv]
// Front stage: branch select, root argument and the three off-pivot numerators.
module rmq_front import rmq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [9*W-1:0]    i_data,
    output logic              o_valid,
    output logic [2*RW-1:0]   o_rad,
    output t_front            o_side
);

    logic signed [W-1:0]  a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [AW-1:0] e00, e11, e22, tr, arg;
    logic signed [MW-1:0] s21m12, s02m20, s10m01, s01p10, s02p20, s12p21;
    logic signed [MW-1:0] num [3];
    logic [1:0]           pc;
    logic                 degen;
    t_front               n_side;
    logic [2*RW-1:0]      n_rad;

    logic                 r_valid;
    logic [2*RW-1:0]      r_rad;
    t_front               r_side;

    always_comb begin
        a00 = i_data[0*W +: W];
        a01 = i_data[1*W +: W];
        a02 = i_data[2*W +: W];
        a10 = i_data[3*W +: W];
        a11 = i_data[4*W +: W];
        a12 = i_data[5*W +: W];
        a20 = i_data[6*W +: W];
        a21 = i_data[7*W +: W];
        a22 = i_data[8*W +: W];
        e00 = AW'(a00);
        e11 = AW'(a11);
        e22 = AW'(a22);
        tr  = e00 + e11 + e22;

        // strict compares: ties go to the later branch
        if (tr > 0) begin
            pc  = PC_TRACE;
            arg = $signed(ONE) + tr;
        end else if (a00 > a11 && a00 > a22) begin
            pc  = PC_M00;
            arg = $signed(ONE) + e00 - e11 - e22;
        end else if (a11 > a22) begin
            pc  = PC_M11;
            arg = $signed(ONE) + e11 - e00 - e22;
        end else begin
            pc  = PC_M22;
            arg = $signed(ONE) + e22 - e00 - e11;
        end
        degen = (arg <= 0);
        n_rad = degen ? '0 : (2*RW)'({arg[AW-2:0], {FRAC_BITS{1'b0}}});

        s21m12 = MW'(a21) - MW'(a12);
        s02m20 = MW'(a02) - MW'(a20);
        s10m01 = MW'(a10) - MW'(a01);
        s01p10 = MW'(a01) + MW'(a10);
        s02p20 = MW'(a02) + MW'(a20);
        s12p21 = MW'(a12) + MW'(a21);

        // lanes hold the non-pivot components in w,x,y,z order
        case (pc)
            PC_TRACE: begin
                num[0] = s21m12; num[1] = s02m20; num[2] = s10m01;
            end
            PC_M00: begin
                num[0] = s21m12; num[1] = s01p10; num[2] = s02p20;
            end
            PC_M11: begin
                num[0] = s02m20; num[1] = s01p10; num[2] = s12p21;
            end
            default: begin
                num[0] = s10m01; num[1] = s02p20; num[2] = s12p21;
            end
        endcase

        n_side.pc    = pc;
        n_side.degen = degen;
        for (int l = 0; l < 3; l++) begin
            n_side.neg[l] = num[l][MW-1];
            n_side.mag[l] = num[l][MW-1] ? t_mag'(-num[l]) : t_mag'(num[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

[sv/rmq_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module rmq_sqrt import rmq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad,
    input  t_front          i_side,
    output logic            o_valid,
    output t_root           o_root,
    output t_front          o_side
);

    logic            r_v    [RW];
    logic [2*RW-1:0] r_rad  [RW];
    logic [RW+1:0]   r_rem  [RW];
    t_root           r_root [RW];
    t_front          r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic            v_in;
        logic [2*RW-1:0] rad_in;
        logic [RW+1:0]   rem_in;
        t_root           root_in;
        t_front          side_in;
        logic [RW+1:0]   rem_sh, trial, n_rem;
        t_root           n_root;

        if (k == 0) begin : g_head
            assign v_in    = i_valid;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_body
            assign v_in    = r_v[k-1];
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            rem_sh = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
            trial  = {root_in, 2'b01};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {root_in[RW-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {root_in[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= rad_in << 2;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

[sv/rmq_div.sv]
// Three-lane pipelined restoring divider by S, one quotient bit per stage.
module rmq_div import rmq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_root      i_root,
    input  t_front     i_side,
    output logic       o_valid,
    output t_word      o_q [3],
    output logic [2:0] o_ovf,
    output t_side      o_side
);

    // setup stage
    logic [XW-1:0] n_prem [3];
    logic [2:0]    n_povf;
    logic [RW:0]   pr, dvs;
    t_side         n_pside;

    logic          r_pv;
    logic [RW:0]   r_pdvs;
    logic [XW-1:0] r_prem [3];
    logic [2:0]    r_povf;
    t_side         r_pside;

    always_comb begin
        dvs = {i_root, 1'b0};
        pr  = ({1'b0, i_root} + (RW+1)'(1)) >> 1;
        for (int l = 0; l < 3; l++) begin
            n_prem[l] = XW'({i_side.mag[l], {FRAC_BITS{1'b0}}}) + XW'(i_root);
            n_povf[l] = n_prem[l] >= (XW'(dvs) << W);
        end
        n_pside.pc    = i_side.pc;
        n_pside.degen = i_side.degen || (i_root == '0);
        n_pside.neg   = i_side.neg;
        n_pside.pivot = (pr > (RW+1)'(WMAX_U)) ? WMAX_U : W'(pr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pdvs  <= dvs;
            r_prem  <= n_prem;
            r_povf  <= n_povf;
            r_pside <= n_pside;
        end
    end

    logic          r_v    [W];
    logic [RW:0]   r_dvs  [W];
    logic [XW-1:0] r_rem  [W][3];
    t_word         r_q    [W][3];
    logic [2:0]    r_ovf  [W];
    t_side         r_side [W];

    for (genvar k = 0; k < W; k++) begin : g_step
        logic          v_in;
        logic [RW:0]   dvs_in;
        logic [XW-1:0] rem_in [3];
        t_word         q_in   [3];
        logic [2:0]    ovf_in;
        t_side         side_in;
        logic [XW-1:0] sd;
        logic [XW-1:0] n_rem [3];
        t_word         n_q   [3];

        if (k == 0) begin : g_head
            assign v_in    = r_pv;
            assign dvs_in  = r_pdvs;
            assign rem_in  = r_prem;
            assign q_in    = '{default: '0};
            assign ovf_in  = r_povf;
            assign side_in = r_pside;
        end else begin : g_body
            assign v_in    = r_v[k-1];
            assign dvs_in  = r_dvs[k-1];
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
            assign ovf_in  = r_ovf[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            sd = XW'(dvs_in) << (W - 1 - k);
            for (int l = 0; l < 3; l++) begin
                if (rem_in[l] >= sd) begin
                    n_rem[l] = rem_in[l] - sd;
                    n_q[l]   = {q_in[l][W-2:0], 1'b1};
                end else begin
                    n_rem[l] = rem_in[l];
                    n_q[l]   = {q_in[l][W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dvs[k]  <= dvs_in;
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
                r_ovf[k]  <= ovf_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_q     = r_q[W-1];
    assign o_ovf   = r_ovf[W-1];
    assign o_side  = r_side[W-1];

endmodule

[sv/rotation_matrix_to_quaternion.sv]
// Registered stages from input transfer to result valid: front, 16 root, setup, 16 divide, out.
// Throughput: one matrix per cycle; the whole pipeline advances together and holds on stall.
// Depth is set by the bit-per-stage square root and the bit-per-stage divider lanes.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; payload is not reset.
// Degenerate input gives zero components with the degenerate flag set.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [9*W-1:0] i_s_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [4*W-1:0] o_m_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic [2:0]     o_m_tuser    // pivot_case[1:0], degenerate
);

    logic            en;
    logic            f_valid, s_valid, d_valid;
    logic [2*RW-1:0] f_rad;
    t_front          f_side, s_side;
    t_root           s_root;
    t_word           d_q [3];
    logic [2:0]      d_ovf;
    t_side           d_side;
    t_word           lane [3];
    t_word           comp [4];
    logic [4*W-1:0]  n_tdata;

    logic            r_out_valid;
    logic [4*W-1:0]  r_tdata;
    logic [2:0]      r_tuser;

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_valid (f_valid),
        .o_rad   (f_rad),
        .o_side  (f_side)
    );

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_rad   (f_rad),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_root  (s_root),
        .i_side  (s_side),
        .o_valid (d_valid),
        .o_q     (d_q),
        .o_ovf   (d_ovf),
        .o_side  (d_side)
    );

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (d_side.neg[l]) begin
                lane[l] = (d_ovf[l] || d_q[l] > WMIN_U) ? WMIN_U : t_word'(-d_q[l]);
            end else begin
                lane[l] = (d_ovf[l] || d_q[l] > WMAX_U) ? WMAX_U : d_q[l];
            end
        end
        case (d_side.pc)
            PC_TRACE: begin
                comp[0] = d_side.pivot; comp[1] = lane[0];
                comp[2] = lane[1];      comp[3] = lane[2];
            end
            PC_M00: begin
                comp[0] = lane[0];      comp[1] = d_side.pivot;
                comp[2] = lane[1];      comp[3] = lane[2];
            end
            PC_M11: begin
                comp[0] = lane[0];      comp[1] = lane[1];
                comp[2] = d_side.pivot; comp[3] = lane[2];
            end
            default: begin
                comp[0] = lane[0];      comp[1] = lane[1];
                comp[2] = lane[2];      comp[3] = d_side.pivot;
            end
        endcase
        n_tdata = d_side.degen ? '0 : {comp[3], comp[2], comp[1], comp[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tdata <= n_tdata;
            r_tuser <= {d_side.degen, d_side.pc};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

endmodule

[bench/rmq_checker.sv]
// Checker: watches both stream channels, predicts quaternions and compares results.
`timescale 1ns / 100ps
module rmq_checker import rmq_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_s_tready,
    input  logic [9*W-1:0] i_s_tdata,
    input  logic           i_m_tvalid,
    input  logic           i_m_tready,
    input  logic [4*W-1:0] i_m_tdata,
    input  logic [2:0]     i_m_tuser,
    output int             o_errors,
    output int             o_pending
);

    typedef struct packed {
        logic [1:0] pc;
        logic       degen;
        t_word      qw, qx, qy, qz;
    } t_quat;

    t_quat quat_fifo[$];
    int errors = 0;

    assign o_errors  = errors;
    assign o_pending = quat_fifo.size();

    function automatic t_word sat_word(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (W - 1)) - 1;
        lo = -(64'sd1 <<< (W - 1));
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return t_word'(v);
    endfunction

    function automatic longint int_sqrt(longint n);
        longint root, step;
        root = 0;
        step = 64'sd1 <<< 62;
        while (step > n) step = step >>> 2;
        while (step != 0) begin
            if (n >= root + step) begin
                n = n - (root + step);
                root = (root >>> 1) + step;
            end else begin
                root = root >>> 1;
            end
            step = step >>> 2;
        end
        return root;
    endfunction

    // num * 2^FRAC / (2r), magnitude rounded half away from zero
    function automatic t_word div_by_s(longint num, longint r);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< FRAC_BITS) + r) / (2 * r);
        return sat_word((num < 0) ? -q : q);
    endfunction

    function automatic t_quat matrix_to_quat(logic [9*W-1:0] d);
        longint a [9];
        longint tr, arg, r;
        t_word pv;
        t_quat q;
        for (int i = 0; i < 9; i++) a[i] = longint'(signed'(d[i*W +: W]));
        tr = a[0] + a[4] + a[8];
        q = '0;
        if (tr > 0) begin
            q.pc = PC_TRACE; arg = (64'sd1 <<< FRAC_BITS) + tr;
        end else if (a[0] > a[4] && a[0] > a[8]) begin
            q.pc = PC_M00; arg = (64'sd1 <<< FRAC_BITS) + a[0] - a[4] - a[8];
        end else if (a[4] > a[8]) begin
            q.pc = PC_M11; arg = (64'sd1 <<< FRAC_BITS) + a[4] - a[0] - a[8];
        end else begin
            q.pc = PC_M22; arg = (64'sd1 <<< FRAC_BITS) + a[8] - a[0] - a[4];
        end
        r = (arg > 0) ? int_sqrt(arg <<< FRAC_BITS) : 0;
        if (arg <= 0 || r == 0) begin
            q.degen = 1'b1;
            return q;
        end
        pv = sat_word((r + 1) >>> 1);
        case (q.pc)
            PC_TRACE: begin
                q.qw = pv;
                q.qx = div_by_s(a[7] - a[5], r);
                q.qy = div_by_s(a[2] - a[6], r);
                q.qz = div_by_s(a[3] - a[1], r);
            end
            PC_M00: begin
                q.qw = div_by_s(a[7] - a[5], r);
                q.qx = pv;
                q.qy = div_by_s(a[1] + a[3], r);
                q.qz = div_by_s(a[2] + a[6], r);
            end
            PC_M11: begin
                q.qw = div_by_s(a[2] - a[6], r);
                q.qx = div_by_s(a[1] + a[3], r);
                q.qy = pv;
                q.qz = div_by_s(a[5] + a[7], r);
            end
            default: begin
                q.qw = div_by_s(a[3] - a[1], r);
                q.qx = div_by_s(a[2] + a[6], r);
                q.qy = div_by_s(a[5] + a[7], r);
                q.qz = pv;
            end
        endcase
        return q;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_quat e;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) quat_fifo.push_back(matrix_to_quat(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (quat_fifo.size() == 0) begin
                    errors++;
                    $error("result transfer with no expected quaternion");
                end else begin
                    e = quat_fifo.pop_front();
                    check_field("quat_w", signed'(e.qw), signed'(i_m_tdata[0 +: W]));
                    check_field("quat_x", signed'(e.qx), signed'(i_m_tdata[W +: W]));
                    check_field("quat_y", signed'(e.qy), signed'(i_m_tdata[2*W +: W]));
                    check_field("quat_z", signed'(e.qz), signed'(i_m_tdata[3*W +: W]));
                    check_field("pivot_case", e.pc, i_m_tuser[1:0]);
                    check_field("degenerate", e.degen, i_m_tuser[2]);
                end
            end
        end
    end

endmodule

[bench/tb.sv]
// Testbench top: drives matrices, stalls the result side, and reports the verdict.
`timescale 1ns / 100ps
module tb;
    import rmq_pkg::*;

    localparam int N_RANDOM  = 1530;
    localparam int CALM_TAIL = 150;
    localparam int WD_LIMIT  = 2000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [9*W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [4*W-1:0] m_tdata;
    logic [2:0]     m_tuser;
    int             errors, pending;
    bit             calm = 1'b0;
    int             idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rotation_matrix_to_quaternion uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    rmq_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    // result-side stalls in bursts
    initial begin
        int n;
        @(negedge i_clk);
        forever begin
            m_tready <= 1'b1;
            n = $urandom_range(0, 15);
            repeat (n) @(negedge i_clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_matrix(logic [9*W-1:0] d);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [9*W-1:0] pack9(int e [9]);
        logic [9*W-1:0] d;
        for (int i = 0; i < 9; i++) d[i*W +: W] = W'(e[i]);
        return d;
    endfunction

    function automatic int rnd_word();
        return int'(signed'(W'($urandom)));
    endfunction

    // near-rotation: all entries in [-one, one], two diagonal entries set by sign to favour a random pivot
    function automatic logic [9*W-1:0] near_rotation();
        int e [9];
        int one;
        one = 1 << FRAC_BITS;
        for (int i = 0; i < 9; i++) e[i] = $urandom_range(0, 2 * one) - one;
        case ($urandom_range(0, 3))
            0: begin e[0] = $urandom_range(0, one); e[4] = $urandom_range(0, one); end
            1: begin e[4] = -$urandom_range(0, one); e[8] = -$urandom_range(0, one); end
            2: begin e[0] = -$urandom_range(0, one); e[8] = -$urandom_range(0, one); end
            default: begin e[0] = -$urandom_range(0, one); e[4] = -$urandom_range(0, one); end
        endcase
        return pack9(e);
    endfunction

    initial begin
        int one, hi, lo;
        int e [9];
        one = 1 << FRAC_BITS;
        hi = (1 << (W - 1)) - 1;
        lo = -(1 << (W - 1));
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // identity and 180-degree turns about each axis
        send_matrix(pack9('{one, 0, 0, 0, one, 0, 0, 0, one}));
        send_matrix(pack9('{one, 0, 0, 0, -one, 0, 0, 0, -one}));
        send_matrix(pack9('{-one, 0, 0, 0, one, 0, 0, 0, -one}));
        send_matrix(pack9('{-one, 0, 0, 0, -one, 0, 0, 0, one}));
        // ties on the diagonal, with zero or negative trace
        send_matrix(pack9('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        send_matrix(pack9('{-100, 5, 6, 7, -100, 8, 9, 10, -100}));
        send_matrix(pack9('{50, 1, 2, 3, 50, 4, 5, 6, -100}));
        send_matrix(pack9('{-200, 1, 2, 3, 100, 4, 5, 6, 100}));
        // diagonal-only matrices, one with full-scale entries
        send_matrix(pack9('{lo, 0, 0, 0, hi, 0, 0, 0, hi}));
        send_matrix(pack9('{-one, 0, 0, 0, 0, 0, 0, 0, 0}));
        send_matrix(pack9('{0, 0, 0, 0, 0, 0, 0, 0, -one}));
        // extremes and saturation
        send_matrix(pack9('{hi, hi, hi, hi, hi, hi, hi, hi, hi}));
        send_matrix(pack9('{lo, lo, lo, lo, lo, lo, lo, lo, lo}));
        send_matrix(pack9('{1, hi, lo, lo, 0, hi, hi, lo, 0}));
        send_matrix(pack9('{hi, lo, hi, hi, lo, lo, lo, hi, lo}));
        send_matrix(pack9('{lo, hi, lo, lo, lo, hi, hi, lo, hi}));
        send_matrix(pack9('{-1, -1, -1, -1, -1, -1, -1, -1, -1}));
        send_matrix(pack9('{1, 0, 0, 0, 0, 0, 0, 0, 0}));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - CALM_TAIL) calm = 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                for (int i = 0; i < 9; i++) e[i] = rnd_word();
                send_matrix(pack9(e));
            end else begin
                send_matrix(near_rotation());
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[rotation_matrix_to_quaternion.f]
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion.sv
bench/rmq_checker.sv
bench/tb.sv
